// ===== hw/rtl/soft_power_button_latch_top_defines.svh =====
// assertion macros for the soft power button latch
// used by soft_power_button_latch_top, needs clk and rst in scope
`ifndef SOFT_POWER_BUTTON_LATCH_TOP_DEFINES_SVH
`define SOFT_POWER_BUTTON_LATCH_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define SPBL_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SPBL_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spbl_pkg.sv =====
// types, codes and reset constants for the soft power button latch
// no dependencies
package spbl_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned LimW  = 16;
  localparam int unsigned CodeW = 3;
  localparam int unsigned IdxW  = 2;

  localparam logic [LimW-1:0] PressDefault   = 16'd20;
  localparam logic [LimW-1:0] ReleaseDefault = 16'd20;
  localparam logic [LimW-1:0] OffDefault     = 16'd1000;

  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_SOURCE  = 6'b000010,
    PH_PRESS   = 6'b000100,
    PH_RELEASE = 6'b001000,
    PH_OFFCHK  = 6'b010000,
    PH_OFF     = 6'b100000
  } phase_t;

  localparam logic [CodeW-1:0] CODE_START   = 3'd0;
  localparam logic [CodeW-1:0] CODE_SOURCE  = 3'd1;
  localparam logic [CodeW-1:0] CODE_PRESS   = 3'd2;
  localparam logic [CodeW-1:0] CODE_RELEASE = 3'd3;
  localparam logic [CodeW-1:0] CODE_OFFCHK  = 3'd4;
  localparam logic [CodeW-1:0] CODE_OFF     = 3'd5;

  typedef enum logic [IdxW-1:0] {
    REG_PRESS   = 2'd0,
    REG_RELEASE = 2'd1,
    REG_OFF     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LimW-1:0] press_ms;
    logic [LimW-1:0] release_ms;
    logic [LimW-1:0] off_ms;
  } cfg_t;

  function automatic logic [CodeW-1:0] code_of(input phase_t ph);
    logic [CodeW-1:0] c;
    c = CODE_START;
    unique case (ph)
      PH_START:   c = CODE_START;
      PH_SOURCE:  c = CODE_SOURCE;
      PH_PRESS:   c = CODE_PRESS;
      PH_RELEASE: c = CODE_RELEASE;
      PH_OFFCHK:  c = CODE_OFFCHK;
      PH_OFF:     c = CODE_OFF;
      default:    c = CODE_START;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/spbl_cfg.sv =====
// debounce and hold-off threshold registers
// depends on spbl_pkg
module spbl_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [spbl_pkg::IdxW-1:0]   cfg_index,
  input  logic [spbl_pkg::LimW-1:0]   cfg_wdata,
  output spbl_pkg::cfg_t              cfg
);

  spbl_pkg::cfg_t cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.press_ms   <= spbl_pkg::PressDefault;
      cfg_q.release_ms <= spbl_pkg::ReleaseDefault;
      cfg_q.off_ms     <= spbl_pkg::OffDefault;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spbl_pkg::REG_PRESS:   cfg_q.press_ms   <= cfg_wdata;
        spbl_pkg::REG_RELEASE: cfg_q.release_ms <= cfg_wdata;
        spbl_pkg::REG_OFF:     cfg_q.off_ms     <= cfg_wdata;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

// ===== hw/rtl/spbl_in_stage.sv =====
// input register for one poll beat
// depends on spbl_pkg
module spbl_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [spbl_pkg::TimeW-1:0] now_ms,
  input  logic                       button_level,
  input  logic                       advance,
  output logic                       in_stall,
  output logic                       s1_valid,
  output logic [spbl_pkg::TimeW-1:0] s1_now,
  output logic                       s1_level
);

  logic load;

  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_now   <= now_ms;
      s1_level <= button_level;
    end
  end

endmodule

// ===== hw/rtl/spbl_fsm.sv =====
// phase state machine, mark time and power hold level
// depends on spbl_pkg
module spbl_fsm (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [spbl_pkg::TimeW-1:0] now,
  input  logic                       level,
  input  spbl_pkg::cfg_t             cfg,
  output logic                       hold,
  output spbl_pkg::phase_t           phase
);

  spbl_pkg::phase_t           phase_next;
  logic [spbl_pkg::TimeW-1:0] mark_time, mark_time_next;
  logic                       hold_next;
  logic [spbl_pkg::TimeW-1:0] elapsed;
  logic [spbl_pkg::LimW-1:0]  limit;
  logic                       met;
  logic                       pressed;

  assign pressed = !level;
  // wrapping difference, modulo 2^32
  assign elapsed = now - mark_time;

  always_comb begin
    limit = cfg.off_ms;
    unique case (phase)
      spbl_pkg::PH_PRESS:   limit = cfg.press_ms;
      spbl_pkg::PH_RELEASE: limit = cfg.release_ms;
      default:              limit = cfg.off_ms;
    endcase
  end

  assign met = elapsed >= {{(spbl_pkg::TimeW-spbl_pkg::LimW){1'b0}}, limit};

  always_comb begin
    phase_next     = phase;
    mark_time_next = mark_time;
    hold_next      = hold;
    unique case (phase)
      spbl_pkg::PH_START: begin
        hold_next      = 1'b1;
        mark_time_next = now;
        phase_next     = spbl_pkg::PH_SOURCE;
      end
      spbl_pkg::PH_SOURCE: begin
        mark_time_next = now;
        if (pressed) begin
          phase_next = spbl_pkg::PH_RELEASE;
        end else begin
          hold_next  = 1'b0;
          phase_next = spbl_pkg::PH_PRESS;
        end
      end
      spbl_pkg::PH_PRESS: begin
        if (!pressed) begin
          mark_time_next = now;
        end else if (met) begin
          hold_next      = 1'b1;
          mark_time_next = now;
          phase_next     = spbl_pkg::PH_RELEASE;
        end
      end
      spbl_pkg::PH_RELEASE: begin
        if (pressed) begin
          mark_time_next = now;
        end else if (met) begin
          mark_time_next = now;
          phase_next     = spbl_pkg::PH_OFFCHK;
        end
      end
      spbl_pkg::PH_OFFCHK: begin
        if (!pressed) begin
          mark_time_next = now;
        end else if (met) begin
          phase_next = spbl_pkg::PH_OFF;
        end
      end
      spbl_pkg::PH_OFF: begin
        hold_next = 1'b0;
      end
      default: begin
        phase_next = spbl_pkg::PH_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= spbl_pkg::PH_START;
      mark_time <= '0;
      hold      <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      mark_time <= mark_time_next;
      hold      <= hold_next;
    end
  end

endmodule

// ===== hw/rtl/soft_power_button_latch_top.sv =====
// Soft power button latch. One poll beat (timestamp, button level) gives one
// result beat (power hold, phase code). A poll is taken every clock when the
// result side keeps up. An accepted poll is held in the input register, then
// the phase update registers its result in the state registers together with
// out_valid; the single 32-bit elapsed-time compare in that update sets the
// clock rate. Threshold writes must be made only while no poll is in flight.
// depends on spbl_pkg, spbl_cfg, spbl_in_stage, spbl_fsm and the defines header
`include "soft_power_button_latch_top_defines.svh"

module soft_power_button_latch_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [spbl_pkg::IdxW-1:0]   cfg_index,
  input  logic [spbl_pkg::LimW-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spbl_pkg::TimeW-1:0]  now_ms,
  input  logic                        button_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        power_hold,
  output logic [spbl_pkg::CodeW-1:0]  phase_code
);

  spbl_pkg::cfg_t             cfg;
  spbl_pkg::phase_t           phase;
  logic                       advance;
  logic                       step;
  logic                       s1_valid;
  logic [spbl_pkg::TimeW-1:0] s1_now;
  logic                       s1_level;
  logic                       is_off;
  logic                       is_up;

  // the state registers double as the result register
  assign advance = !out_valid || !out_stall;
  assign step    = s1_valid && advance;

  spbl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spbl_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .now_ms       (now_ms),
    .button_level (button_level),
    .advance      (advance),
    .in_stall     (in_stall),
    .s1_valid     (s1_valid),
    .s1_now       (s1_now),
    .s1_level     (s1_level)
  );

  spbl_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .now   (s1_now),
    .level (s1_level),
    .cfg   (cfg),
    .hold  (power_hold),
    .phase (phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  assign phase_code = spbl_pkg::code_of(phase);

  assign is_off = phase == spbl_pkg::PH_OFF;
  assign is_up  = (phase == spbl_pkg::PH_RELEASE) || (phase == spbl_pkg::PH_OFFCHK);

  `SPBL_ASSERT_NEXT(a_off_sticks, is_off, is_off, "left off phase")
  `SPBL_ASSERT_NOW(a_hold_on, is_up, power_hold, "hold dropped while powered")
  `SPBL_ASSERT_NEXT(a_off_drops, is_off && step, !power_hold, "hold kept in off phase")
  `SPBL_ASSERT_NOW(a_stall_src, in_stall, s1_valid && out_valid, "stall without a pending beat")

endmodule
